// File: rtl/fbdc_pkg.sv
// Package: shared widths, reset values, register indexes and types of the dual CRC block.
package fbdc_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CRC32_W   = 32;
    localparam int unsigned CRC16_W   = 16;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned NBITS_W   = 6;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [CRC32_W-1:0] DIV32_RESET = 32'h04C1_1DB7;
    localparam logic [CRC16_W-1:0] DIV16_RESET = 16'h1021;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIV32 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIV16 = 1'd1;

    localparam logic [NBITS_W-1:0] MAX_BITS = 6'd32;

    // One word held in the input register
    typedef struct packed {
        logic [WORD_W-1:0]  data_word;
        logic [NBITS_W-1:0] nbits;      // already clamped to 32
        logic               last_word;
    } item_t;

    // Divider state after one word
    typedef struct packed {
        logic [CRC32_W-1:0] crc32;
        logic [CRC16_W-1:0] crc16;
        logic [COUNT_W-1:0] count;
    } crc_state_t;

endpackage

// File: rtl/fbdc_in_stage.sv
// Input register: accepts one word transaction and holds it until the step logic advances.
module fbdc_in_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fbdc_pkg::WORD_W-1:0]       s_data_word,
    input  logic [fbdc_pkg::NBITS_W-1:0]      s_bits_valid,
    input  logic                              s_last_word,
    input  logic                              advance,
    output logic                              item_valid,
    output fbdc_pkg::item_t                   item
);

    logic            valid_reg;
    logic            valid_next;
    fbdc_pkg::item_t item_reg;
    fbdc_pkg::item_t item_next;
    logic            take;

    assign s_ready = !valid_reg || advance;
    assign take    = s_valid && s_ready;

    always_comb begin
        item_next = item_reg;
        if (take) begin
            item_next.data_word = s_data_word;
            // clamp counts above a full word
            item_next.nbits     = (s_bits_valid > fbdc_pkg::MAX_BITS) ?
                                  fbdc_pkg::MAX_BITS : s_bits_valid;
            item_next.last_word = s_last_word;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/fbdc_step.sv
// Step logic: feeds up to 32 bits of one word through both bitwise dividers.
module fbdc_step (
    input  fbdc_pkg::item_t                   item,
    input  fbdc_pkg::crc_state_t              cur,
    input  logic [fbdc_pkg::CRC32_W-1:0]      div32,
    input  logic [fbdc_pkg::CRC16_W-1:0]      div16,
    output fbdc_pkg::crc_state_t              nxt
);

    always_comb begin
        logic [fbdc_pkg::CRC32_W-1:0] r32;
        logic [fbdc_pkg::CRC16_W-1:0] r16;
        logic [fbdc_pkg::WORD_W-1:0]  swapped;
        logic [fbdc_pkg::NBITS_W-1:0] zeros;
        logic                         b32;
        logic                         b16;
        logic                         top32;
        logic                         top16;

        r32     = cur.crc32;
        r16     = cur.crc16;
        // low halfword first, then high halfword
        swapped = {item.data_word[fbdc_pkg::CRC16_W-1:0],
                   item.data_word[fbdc_pkg::WORD_W-1:fbdc_pkg::CRC16_W]};
        zeros   = '0;
        b32     = 1'b0;
        b16     = 1'b0;
        top32   = 1'b0;
        top16   = 1'b0;
        for (int i = 0; i < fbdc_pkg::WORD_W; i++) begin
            if (i < int'(item.nbits)) begin
                b32   = item.data_word[fbdc_pkg::WORD_W-1-i];
                b16   = swapped[fbdc_pkg::WORD_W-1-i];
                top32 = r32[fbdc_pkg::CRC32_W-1];
                top16 = r16[fbdc_pkg::CRC16_W-1];
                r32   = {r32[fbdc_pkg::CRC32_W-2:0], b32}
                        ^ (div32 & {fbdc_pkg::CRC32_W{top32}});
                r16   = {r16[fbdc_pkg::CRC16_W-2:0], b16}
                        ^ (div16 & {fbdc_pkg::CRC16_W{top16}});
                zeros = zeros + {{(fbdc_pkg::NBITS_W-1){1'b0}}, !top16};
            end
        end
        nxt.crc32 = r32;
        nxt.crc16 = r16;
        nxt.count = cur.count + {{(fbdc_pkg::COUNT_W-fbdc_pkg::NBITS_W){1'b0}}, zeros};
    end

endmodule

// File: rtl/fbdc_out_stage.sv
// Output register: holds one result transaction until the receiver takes it.
module fbdc_out_stage (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              load,
    input  fbdc_pkg::crc_state_t              res,
    output logic                              out_free,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fbdc_pkg::CRC32_W-1:0]      m_crc32_result,
    output logic [fbdc_pkg::CRC16_W-1:0]      m_crc16_result,
    output logic [fbdc_pkg::COUNT_W-1:0]      m_unreduced_steps
);

    logic                 valid_reg;
    logic                 valid_next;
    fbdc_pkg::crc_state_t res_reg;
    fbdc_pkg::crc_state_t res_next;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load) begin
            valid_next = 1'b1;
            res_next   = res;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid           = valid_reg;
    assign m_crc32_result    = res_reg.crc32;
    assign m_crc16_result    = res_reg.crc16;
    assign m_unreduced_steps = res_reg.count;

endmodule

// File: rtl/flash_block_dual_crc_unit.sv
// Top level: dual CRC-32 / CRC-16 checker over a stream of 32-bit memory words.
//
// Usage:
//   The s_ channel carries one word transaction: data word, number of leading bits
//   to consume (above 32 counts as 32) and a last flag. Each consumed bit steps
//   both dividers MSB first; the CRC-16 divider takes the low halfword first.
//   Only a last word produces an m_ transaction with both remainders and the count
//   of CRC-16 steps without reduction; the running state then clears.
//   The cfg port writes the divisors (index 0: CRC-32, index 1: CRC-16);
//   write only while no word is in flight.
// Timing:
//   One word per cycle sustained while no last word waits on the output register. A word
//   sits in the input register, where the step network folds its bits into the state;
//   m_valid rises the cycle after the last word leaves the input register.
// Reset:
//   Synchronous, active low. Both registers empty, running state zero, divisors
//   back to 0x04C11DB7 and 0x1021.
// Stall:
//   A held result blocks only a following last word, which waits in the input
//   register with s_ready low until m_ready frees the output register.
module flash_block_dual_crc_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [fbdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbdc_pkg::CFG_DAT_W-1:0]      cfg_wr_data,
    // word input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fbdc_pkg::WORD_W-1:0]         s_data_word,
    input  logic [fbdc_pkg::NBITS_W-1:0]        s_bits_valid,
    input  logic                                s_last_word,
    // result output
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fbdc_pkg::CRC32_W-1:0]        m_crc32_result,
    output logic [fbdc_pkg::CRC16_W-1:0]        m_crc16_result,
    output logic [fbdc_pkg::COUNT_W-1:0]        m_unreduced_steps
);

    logic [fbdc_pkg::CRC32_W-1:0] div32_reg;
    logic [fbdc_pkg::CRC32_W-1:0] div32_next;
    logic [fbdc_pkg::CRC16_W-1:0] div16_reg;
    logic [fbdc_pkg::CRC16_W-1:0] div16_next;

    fbdc_pkg::crc_state_t state_reg;
    fbdc_pkg::crc_state_t state_next;
    fbdc_pkg::crc_state_t step_res;

    fbdc_pkg::item_t item;
    logic            item_valid;
    logic            advance;
    logic            load;
    logic            out_free;

    // Divisor registers: decode the index, ignore anything else
    always_comb begin
        div32_next = div32_reg;
        div16_next = div16_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                fbdc_pkg::REG_DIV32: div32_next = cfg_wr_data;
                fbdc_pkg::REG_DIV16: div16_next = cfg_wr_data[fbdc_pkg::CRC16_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div32_reg <= fbdc_pkg::DIV32_RESET;
            div16_reg <= fbdc_pkg::DIV16_RESET;
        end else begin
            div32_reg <= div32_next;
            div16_reg <= div16_next;
        end
    end

    // Hold a last word until the output register can take its result
    assign advance = item_valid && (!item.last_word || out_free);
    assign load    = advance && item.last_word;

    fbdc_in_stage u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_word  (s_data_word),
        .s_bits_valid (s_bits_valid),
        .s_last_word  (s_last_word),
        .advance      (advance),
        .item_valid   (item_valid),
        .item         (item)
    );

    fbdc_step u_step (
        .item  (item),
        .cur   (state_reg),
        .div32 (div32_reg),
        .div16 (div16_reg),
        .nxt   (step_res)
    );

    // Running state: advance on every word, clear when a block's result is loaded
    always_comb begin
        state_next = state_reg;
        if (advance) begin
            state_next = item.last_word ? '0 : step_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else begin
            state_reg <= state_next;
        end
    end

    fbdc_out_stage u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (load),
        .res               (step_res),
        .out_free          (out_free),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_crc32_result    (m_crc32_result),
        .m_crc16_result    (m_crc16_result),
        .m_unreduced_steps (m_unreduced_steps)
    );

    // State is zero right after a block's result has been loaded
    a_clear_after_last : assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (state_reg == '0))
        else $error("running state not cleared after last word");

    // A result appears only after a last word advanced
    a_result_source : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(load))
        else $error("result raised without a last word");

    // An empty input register always takes a transaction
    a_ready_when_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !item_valid |-> s_ready)
        else $error("input register empty but not ready");

    // A blocked word keeps the state untouched
    a_state_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && !advance) |=> $stable(state_reg) && item_valid)
        else $error("state moved while word was blocked");

endmodule
